// ----- hdl/trs_pkg.sv -----
package trs_pkg;

	// input opcodes, carried in tuser
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_PACKET = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	// TFTP packet types of interest
	localparam logic [15:0] PKT_DATA  = 16'd3;
	localparam logic [15:0] PKT_ERROR = 16'd5;

	// status codes
	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_BUSY      = 3'd1;
	localparam logic [2:0] ST_OK        = 3'd2;
	localparam logic [2:0] ST_RUNT      = 3'd3;
	localparam logic [2:0] ST_SERVER    = 3'd4;
	localparam logic [2:0] ST_EXHAUSTED = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_TIMEOUT_MS    = 2'd0;
	localparam logic [1:0] REG_MAX_TRIES     = 2'd1;
	localparam logic [1:0] REG_IMAGE_MAX_LEN = 2'd2;

	localparam int CFG_W = 25;

	localparam logic [15:0] TIMEOUT_RST   = 16'd500;
	localparam logic [7:0]  MAX_TRIES_RST = 8'd10;
	localparam logic [24:0] IMAGE_MAX_RST = 25'h1000000;

	localparam logic [15:0] HDR_BYTES = 16'd4;
	localparam logic [15:0] MIN_LEN   = 16'd2;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 104;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_RRQ  = 4'b0010,
		PH_ACK  = 4'b0100,
		PH_DONE = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] packet_length;
		logic [15:0] packet_type;
		logic [15:0] block_number;
	} item_t;

	typedef struct packed {
		logic        send_request;
		logic        send_ack;
		logic [15:0] ack_block;
		logic        lock_peer;
		logic        store_enable;
		logic [31:0] store_offset;
		logic [15:0] store_length;
		logic [2:0]  status;
		logic [31:0] received_bytes;
	} result_t;

	typedef struct packed {
		logic [15:0] timeout_ms;
		logic [7:0]  max_tries;
		logic [24:0] image_max_len;
	} cfg_t;

endpackage

// ----- hdl/trs_cfg_regs.sv -----
module trs_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [1:0]                cfg_addr,
	input  logic [trs_pkg::CFG_W-1:0] cfg_wdata,
	output trs_pkg::cfg_t             cfg
);

	trs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms    <= trs_pkg::TIMEOUT_RST;
			cfg_q.max_tries     <= trs_pkg::MAX_TRIES_RST;
			cfg_q.image_max_len <= trs_pkg::IMAGE_MAX_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				trs_pkg::REG_TIMEOUT_MS:    cfg_q.timeout_ms    <= cfg_wdata[15:0];
				trs_pkg::REG_MAX_TRIES:     cfg_q.max_tries     <= cfg_wdata[7:0];
				trs_pkg::REG_IMAGE_MAX_LEN: cfg_q.image_max_len <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/trs_in_reg.sv -----
module trs_in_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [trs_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [1:0]                    s_tuser,
	input  logic                          step_ready,
	output logic                          item_valid,
	output trs_pkg::item_t                item
);

	logic           valid_s1;
	trs_pkg::item_t item_s1;
	logic           take;

	// the held request leaves whenever the core can take it
	assign s_tready = !valid_s1 || step_ready;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.opcode        <= s_tuser;
			item_s1.packet_length <= s_tdata[15:0];
			item_s1.packet_type   <= s_tdata[31:16];
			item_s1.block_number  <= s_tdata[47:32];
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

// ----- hdl/trs_core.sv -----
module trs_core (
	input  logic             clk,
	input  logic             arst_n,
	input  trs_pkg::cfg_t    cfg,
	input  logic             fire,
	input  trs_pkg::item_t   item,
	output trs_pkg::result_t res
);

	trs_pkg::phase_t phase_q, n_phase;
	logic [15:0] prev_blk_q, n_prev_blk;
	logic [15:0] prev_size_q, n_prev_size;
	logic [31:0] byte_count_q, n_byte_count;
	logic [7:0]  retry_q, n_retry;
	logic [15:0] elapsed_q, n_elapsed;
	logic [2:0]  final_q, n_final;

	logic        busy;
	logic        fin;
	logic [15:0] pl;
	logic [15:0] exp_next;
	logic [32:0] sum;
	logic [7:0]  rc_inc;

	assign busy     = (phase_q == trs_pkg::PH_RRQ) || (phase_q == trs_pkg::PH_ACK);
	assign pl       = (item.packet_length >= trs_pkg::HDR_BYTES) ?
		item.packet_length - trs_pkg::HDR_BYTES : 16'd0;
	assign exp_next = prev_blk_q + 16'd1;
	assign sum      = {1'b0, byte_count_q} + {17'd0, pl};
	assign rc_inc   = (retry_q != 8'hFF) ? retry_q + 8'd1 : retry_q;

	always_comb begin
		n_phase      = phase_q;
		n_prev_blk   = prev_blk_q;
		n_prev_size  = prev_size_q;
		n_byte_count = byte_count_q;
		n_retry      = retry_q;
		n_elapsed    = elapsed_q;
		n_final      = final_q;
		fin          = 1'b0;
		res          = '0;

		case (item.opcode)
			trs_pkg::OP_START: begin
				n_phase          = trs_pkg::PH_RRQ;
				n_prev_blk       = 16'd0;
				n_prev_size      = 16'd0;
				n_byte_count     = 32'd0;
				n_retry          = 8'd0;
				n_elapsed        = 16'd0;
				n_final          = trs_pkg::ST_IDLE;
				res.send_request = 1'b1;
			end
			trs_pkg::OP_PACKET: begin
				if (busy) begin
					n_elapsed = 16'd0;
					n_retry   = 8'd0;
					if (item.packet_length < trs_pkg::MIN_LEN) begin
						fin     = 1'b1;
						n_final = trs_pkg::ST_RUNT;
					end else if (item.packet_type == trs_pkg::PKT_DATA) begin
						if (item.block_number == exp_next) begin
							if (sum <= {8'd0, cfg.image_max_len}) begin
								res.store_enable = 1'b1;
								res.store_offset = byte_count_q;
								res.store_length = pl;
							end
							n_prev_blk   = exp_next;
							n_byte_count = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
							// short payload closes the transfer, no final ACK
							if (pl < prev_size_q) begin
								fin     = 1'b1;
								n_final = trs_pkg::ST_OK;
							end else begin
								n_prev_size  = pl;
								res.send_ack = 1'b1;
							end
						end else if (item.block_number != prev_blk_q) begin
							// out of sequence: re-ACK last good block
							n_prev_size  = pl;
							res.send_ack = 1'b1;
						end
					end else if (item.packet_type == trs_pkg::PKT_ERROR) begin
						fin     = 1'b1;
						n_final = trs_pkg::ST_SERVER;
					end
					if (fin) begin
						n_phase = trs_pkg::PH_DONE;
					end else if (phase_q == trs_pkg::PH_RRQ) begin
						res.lock_peer = 1'b1;
						n_phase       = trs_pkg::PH_ACK;
					end
				end
			end
			trs_pkg::OP_TICK: begin
				if (busy) begin
					if (elapsed_q < cfg.timeout_ms) begin
						n_elapsed = elapsed_q + 16'd1;
					end else begin
						if (phase_q == trs_pkg::PH_ACK && prev_blk_q == 16'd0) begin
							n_phase = trs_pkg::PH_RRQ;
						end
						n_retry = rc_inc;
						if (rc_inc >= {1'b0, cfg.max_tries[7:1]}) begin
							n_phase      = trs_pkg::PH_RRQ;
							n_prev_blk   = 16'd0;
							n_prev_size  = 16'd0;
							n_byte_count = 32'd0;
						end
						if (rc_inc >= cfg.max_tries) begin
							n_phase = trs_pkg::PH_DONE;
							n_final = trs_pkg::ST_EXHAUSTED;
						end else begin
							n_elapsed = 16'd0;
							if (n_phase == trs_pkg::PH_RRQ) begin
								res.send_request = 1'b1;
							end else begin
								res.send_ack = 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase

		if (res.send_ack) begin
			res.ack_block = n_prev_blk;
		end

		case (n_phase)
			trs_pkg::PH_IDLE: res.status = trs_pkg::ST_IDLE;
			trs_pkg::PH_DONE: res.status = n_final;
			default:          res.status = trs_pkg::ST_BUSY;
		endcase
		res.received_bytes = n_byte_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= trs_pkg::PH_IDLE;
			prev_blk_q   <= 16'd0;
			prev_size_q  <= 16'd0;
			byte_count_q <= 32'd0;
			retry_q      <= 8'd0;
			elapsed_q    <= 16'd0;
			final_q      <= trs_pkg::ST_IDLE;
		end else if (fire) begin
			phase_q      <= n_phase;
			prev_blk_q   <= n_prev_blk;
			prev_size_q  <= n_prev_size;
			byte_count_q <= n_byte_count;
			retry_q      <= n_retry;
			elapsed_q    <= n_elapsed;
			final_q      <= n_final;
		end
	end

	a_req_ack_excl: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> !(res.send_request && res.send_ack))
		else $error("read request and ACK issued together");

	a_lock_to_ack: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.lock_peer |=> phase_q == trs_pkg::PH_ACK)
		else $error("peer lock without move to acknowledging");

	a_store_status: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.store_enable |->
		(res.status == trs_pkg::ST_BUSY || res.status == trs_pkg::ST_OK))
		else $error("store window outside a live transfer");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.opcode == trs_pkg::OP_START |=>
		phase_q == trs_pkg::PH_RRQ && byte_count_q == 32'd0 && retry_q == 8'd0)
		else $error("start did not clear transfer state");

endmodule

// ----- hdl/trs_out_reg.sv -----
module trs_out_reg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  trs_pkg::result_t               res,
	output logic                           can_load,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [trs_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic             valid_q;
	trs_pkg::result_t res_q;

	assign can_load = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0,
		res_q.received_bytes,
		res_q.status,
		res_q.store_length,
		res_q.store_offset,
		res_q.store_enable,
		res_q.lock_peer,
		res_q.ack_block,
		res_q.send_ack,
		res_q.send_request};

endmodule

// ----- hdl/tftp_read_client_sequencer.sv -----
// TFTP read-transfer sequencer. Requests come in on the s_ side: tuser selects start,
// received packet header or one-millisecond tick; every request yields exactly one
// result on the m_ side (read request / ACK strobes, peer lock, payload store window,
// status and running byte count). One request is taken per clock while results are not
// stalled; a result is presented from the input register, then the result register, and
// can be taken at the following edge; the combinational state update between those
// registers sets that rate. A stalled result holds the input register, and then
// s_tready drops.
// Configuration writes are taken at any time but are meant for when no transfer is
// in flight; there is no read-back. No clearing pass is needed after reset.
module tftp_read_client_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [1:0]                     cfg_addr,
	input  logic [trs_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// packet_length[15:0], packet_type[31:16], block_number[47:32]
	input  logic [trs_pkg::IN_DATA_W-1:0]  s_tdata,
	// opcode[1:0]
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// send_request[0], send_ack[1], ack_block[17:2], lock_peer[18], store_enable[19],
	// store_offset[51:20], store_length[67:52], status[70:68], received_bytes[102:71]
	output logic [trs_pkg::OUT_DATA_W-1:0] m_tdata
);

	trs_pkg::cfg_t    cfg;
	trs_pkg::item_t   item;
	trs_pkg::result_t res;
	logic             item_valid;
	logic             step_ready;
	logic             fire;

	assign fire = item_valid && step_ready;

	trs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	trs_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.step_ready (step_ready),
		.item_valid (item_valid),
		.item       (item)
	);

	trs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.item   (item),
		.res    (res)
	);

	trs_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire),
		.res      (res),
		.can_load (step_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import trs_pkg::*;

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [1:0] cfg_addr = REG_TIMEOUT_MS;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = OP_NOP;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// predictor state and its copy of the registers
	phase_t xfer_phase = PH_IDLE;
	logic [15:0] exp_prev_blk = '0;
	logic [15:0] last_payload = '0;
	logic [31:0] byte_total = '0;
	logic [7:0] retries = '0;
	logic [15:0] elapsed = '0;
	logic [2:0] final_status = ST_IDLE;
	logic [15:0] cfg_timeout = TIMEOUT_RST;
	logic [7:0] cfg_tries = MAX_TRIES_RST;
	logic [24:0] cfg_image_max = IMAGE_MAX_RST;

	item_t queued_cmds[$];
	result_t predicted[$];
	item_t on_bus;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	logic hold_arm = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;
	int items_queued = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int rrq_seen = 0;
	int acks_seen = 0;
	int stores_seen = 0;
	int mismatches = 0;

	tftp_read_client_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end else begin
			cycle_count <= cycle_count + 1;
		end
	end

	function automatic result_t advance_transfer(input item_t cmd);
		result_t r;
		logic [15:0] payload;
		logic [15:0] next_blk;
		logic [32:0] total;
		logic busy;
		r = '0;
		busy = (xfer_phase == PH_RRQ) || (xfer_phase == PH_ACK);
		case (cmd.opcode)
		OP_START: begin
			xfer_phase = PH_RRQ;
			exp_prev_blk = '0;
			last_payload = '0;
			byte_total = '0;
			retries = '0;
			elapsed = '0;
			final_status = ST_IDLE;
			r.send_request = 1'b1;
		end
		OP_PACKET: if (busy) begin
			elapsed = '0;
			retries = '0;
			if (cmd.packet_length < MIN_LEN) begin
				xfer_phase = PH_DONE;
				final_status = ST_RUNT;
			end else if (cmd.packet_type == PKT_DATA) begin
				payload = (cmd.packet_length >= HDR_BYTES) ? cmd.packet_length - HDR_BYTES : 16'd0;
				next_blk = exp_prev_blk + 16'd1;
				if (cmd.block_number == next_blk) begin
					total = {1'b0, byte_total} + {17'b0, payload};
					if (total <= {8'b0, cfg_image_max}) begin
						r.store_enable = 1'b1;
						r.store_offset = byte_total;
						r.store_length = payload;
					end
					exp_prev_blk = next_blk;
					byte_total = total[32] ? 32'hFFFF_FFFF : total[31:0];
					// a shrinking payload ends the image, no final ACK
					if (payload < last_payload) begin
						xfer_phase = PH_DONE;
						final_status = ST_OK;
					end else begin
						last_payload = payload;
						r.send_ack = 1'b1;
					end
				end else if (cmd.block_number != exp_prev_blk) begin
					last_payload = payload;
					r.send_ack = 1'b1;
				end
			end else if (cmd.packet_type == PKT_ERROR) begin
				xfer_phase = PH_DONE;
				final_status = ST_SERVER;
			end
			if (xfer_phase == PH_RRQ) begin
				r.lock_peer = 1'b1;
				xfer_phase = PH_ACK;
			end
		end
		OP_TICK: if (busy) begin
			if (elapsed < cfg_timeout) begin
				elapsed = elapsed + 16'd1;
			end else begin
				if (xfer_phase == PH_ACK && exp_prev_blk == 16'd0)
					xfer_phase = PH_RRQ;
				if (retries != 8'd255)
					retries = retries + 8'd1;
				if (retries >= (cfg_tries >> 1)) begin
					xfer_phase = PH_RRQ;
					exp_prev_blk = '0;
					last_payload = '0;
					byte_total = '0;
				end
				if (retries >= cfg_tries) begin
					xfer_phase = PH_DONE;
					final_status = ST_EXHAUSTED;
				end else begin
					elapsed = '0;
					if (xfer_phase == PH_RRQ)
						r.send_request = 1'b1;
					else
						r.send_ack = 1'b1;
				end
			end
		end
		default: ;
		endcase
		if (r.send_ack)
			r.ack_block = exp_prev_blk;
		case (xfer_phase)
		PH_IDLE: r.status = ST_IDLE;
		PH_DONE: r.status = final_status;
		default: r.status = ST_BUSY;
		endcase
		r.received_bytes = byte_total;
		return r;
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic check_result(input logic [OUT_DATA_W-1:0] d);
		result_t want;
		results_checked++;
		if (predicted.size() == 0) begin
			$error("result with nothing outstanding: %h", d);
			mismatches++;
		end else begin
			want = predicted.pop_front();
			compare_field("send_request", 32'(want.send_request), 32'(d[0]));
			compare_field("send_ack", 32'(want.send_ack), 32'(d[1]));
			compare_field("ack_block", 32'(want.ack_block), 32'(d[17:2]));
			compare_field("lock_peer", 32'(want.lock_peer), 32'(d[18]));
			compare_field("store_enable", 32'(want.store_enable), 32'(d[19]));
			compare_field("store_offset", want.store_offset, d[51:20]);
			compare_field("store_length", 32'(want.store_length), 32'(d[67:52]));
			compare_field("status", 32'(want.status), 32'(d[70:68]));
			compare_field("received_bytes", want.received_bytes, d[102:71]);
			rrq_seen += want.send_request;
			acks_seen += want.send_ack;
			stores_seen += want.store_enable;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predicted.push_back(advance_transfer(on_bus));
				requests_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (queued_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					on_bus = queued_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {on_bus.block_number, on_bus.packet_type, on_bus.packet_length};
					s_tuser <= on_bus.opcode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_arm)
			hold_left <= HOLD_CYCLES;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	task automatic push_cmd(input logic [1:0] op, input logic [15:0] plen,
		input logic [15:0] ptype, input logic [15:0] blk);
		item_t cmd;
		cmd.opcode = op;
		cmd.packet_length = plen;
		cmd.packet_type = ptype;
		cmd.block_number = blk;
		queued_cmds.push_back(cmd);
		items_queued++;
	endtask

	// size 0 picks a header-only or clamped length
	task automatic push_data(input int blk, input int size);
		push_cmd(OP_PACKET, size == 0 ? 16'($urandom_range(2, 4)) : 16'(size + 4), PKT_DATA,
			16'(blk));
	endtask

	task automatic push_ticks(input int n);
		repeat (n) push_cmd(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic queue_transfer();
		int blk, size, steps, r, i, short_max, burst;
		bit over;
		short_max = (cfg_timeout > 20) ? 2 : cfg_timeout + 2;
		burst = (cfg_timeout > 20) ? 2 : (cfg_timeout + 1) * (cfg_tries + 2);
		if (burst > 300)
			burst = 300;
		case ($urandom_range(3))
		0: size = 0;
		1: size = $urandom_range(1, 16);
		2: size = 512;
		default: size = $urandom_range(0, 65531);
		endcase
		blk = 1;
		over = 0;
		steps = $urandom_range(1, 12);
		push_cmd(OP_START, 16'($urandom), 16'($urandom), 16'($urandom));
		// unknown first packet: locks the peer with no block yet
		if ($urandom_range(4) == 0)
			push_cmd(OP_PACKET, 16'($urandom_range(2, 65535)), 16'($urandom_range(6, 65535)),
				16'($urandom));
		for (i = 0; i < steps && !over; i++) begin
			r = $urandom_range(99);
			push_ticks(r < 6 ? burst : $urandom_range(0, short_max));
			r = $urandom_range(99);
			if (r < 68) begin
				push_data(blk, size);
				blk++;
			end else if (r < 76) begin
				push_data(blk - 1, size);
			end else if (r < 82) begin
				push_data($urandom, size);
			end else if (r < 86) begin
				push_cmd(OP_PACKET, 16'($urandom_range(2, 65535)), 16'($urandom_range(6, 65535)),
					16'($urandom));
			end else if (r < 89) begin
				push_cmd(OP_PACKET, 16'($urandom_range(1)), 16'($urandom), 16'($urandom));
				over = 1;
			end else if (r < 91) begin
				push_cmd(OP_PACKET, 16'($urandom_range(2, 65535)), PKT_ERROR, 16'($urandom));
				over = 1;
			end else if (r < 95) begin
				push_cmd(2'($urandom_range(3)), 16'($urandom), 16'($urandom), 16'($urandom));
			end else begin
				push_data(blk, size > 0 ? $urandom_range(0, size - 1) : 0);
				over = 1;
			end
		end
		if (!over && $urandom_range(1))
			push_data(blk, size > 0 ? $urandom_range(0, size - 1) : 0);
	endtask

	task automatic wait_idle();
		while (queued_cmds.size() != 0 || s_tvalid || predicted.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
		REG_TIMEOUT_MS: cfg_timeout = val[15:0];
		REG_MAX_TRIES: cfg_tries = val[7:0];
		REG_IMAGE_MAX_LEN: cfg_image_max = val[24:0];
		default: ;
		endcase
	endtask

	task automatic set_config(input logic [15:0] tmo, input logic [7:0] tries,
		input logic [24:0] imax);
		write_reg(REG_TIMEOUT_MS, {9'd0, tmo});
		write_reg(REG_MAX_TRIES, {17'd0, tries});
		write_reg(REG_IMAGE_MAX_LEN, imax);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_phase(input logic [15:0] tmo, input logic [7:0] tries,
		input logic [24:0] imax, input int tx, input int rx, input int n,
		input bit hold, input bit pause);
		int target;
		bit paused;
		wait_idle();
		set_config(tmo, tries, imax);
		tx_idle_pct = tx;
		rx_stall_pct = rx;
		target = items_queued + n;
		paused = 0;
		while (items_queued < target) begin
			queue_transfer();
			// let the block drain completely mid-phase
			if (pause && !paused && items_queued >= target - n / 2) begin
				wait_idle();
				paused = 1;
			end
		end
		if (hold) begin
			@(posedge clk);
			hold_arm <= 1'b1;
			@(posedge clk);
			hold_arm <= 1'b0;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset register values
		push_cmd(OP_TICK, 16'd0, 16'd0, 16'd0);
		push_cmd(OP_PACKET, 16'd516, PKT_DATA, 16'd1);
		push_cmd(OP_NOP, 16'd0, 16'd0, 16'd0);
		push_cmd(OP_START, 16'd0, 16'd0, 16'd0);
		push_cmd(OP_PACKET, 16'd8, 16'h1234, 16'd0);
		push_cmd(OP_PACKET, 16'd516, PKT_DATA, 16'd1);
		push_cmd(OP_PACKET, 16'd516, PKT_DATA, 16'd1);
		push_cmd(OP_PACKET, 16'd516, PKT_DATA, 16'd5);
		push_cmd(OP_PACKET, 16'd516, PKT_DATA, 16'd2);
		push_cmd(OP_PACKET, 16'd100, PKT_DATA, 16'd3);
		push_cmd(OP_TICK, 16'd0, 16'd0, 16'd0);
		push_cmd(OP_START, 16'd0, 16'd0, 16'd0);
		push_cmd(OP_PACKET, 16'd1, PKT_DATA, 16'd1);
		push_cmd(OP_START, 16'd0, 16'd0, 16'd0);
		push_cmd(OP_PACKET, 16'd3, PKT_DATA, 16'd1);
		push_cmd(OP_START, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_cmd(OP_PACKET, 16'd4, PKT_ERROR, 16'hFFFF);
		push_cmd(OP_START, 16'd0, 16'd0, 16'd0);
		push_cmd(OP_PACKET, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_cmd(OP_PACKET, 16'd2, PKT_DATA, 16'd1);
		push_cmd(OP_PACKET, 16'd516, PKT_DATA, 16'd0);
		push_cmd(OP_PACKET, 16'd0, 16'd0, 16'd0);
		push_cmd(OP_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF);

		run_phase(16'd3, 8'd4, 25'd4096, 0, 0, 60, 1, 0);
		run_phase(16'd0, 8'd0, 25'd0, 86, 0, 60, 0, 0);
		run_phase(16'd1, 8'd1, 25'd100, 0, 86, 60, 0, 0);
		run_phase(16'd2, 8'd6, 25'($urandom_range(0, 33554431)), 37, 37, 60, 0, 0);
		run_phase(16'd5, 8'd10, IMAGE_MAX_RST, 86, 0, 60, 0, 1);
		run_phase(16'($urandom_range(1, 8)), 8'($urandom_range(2, 12)),
			25'($urandom_range(0, 33554431)), 0, 86, 60, 0, 0);
		run_phase(16'hFFFF, 8'hFF, 25'h1FF_FFFF, 37, 37, 60, 0, 0);

		wait_idle();
		repeat (8) @(posedge clk);
		$display("tb: %0d requests (directed, seven random phases), %0d results",
			requests_sent, results_checked);
		$display("tb: %0d read requests, %0d ACKs, %0d store windows, %0d mismatches",
			rrq_seen, acks_seen, stores_seen, mismatches);
		if (mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// ----- tftp_read_client_sequencer.f -----
hdl/trs_pkg.sv
hdl/trs_cfg_regs.sv
hdl/trs_in_reg.sv
hdl/trs_core.sv
hdl/trs_out_reg.sv
hdl/tftp_read_client_sequencer.sv
tb/sv/tb.sv
